@@ hdl/tq_pkg.sv @@
// Shared types and constants for the timer queue with wall clock.
package tq_pkg;

  // Command codes on the input channel.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ENQUEUE = 1'b1;

  // Wall clock limits and register reset value.
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_WRAP    = 100;
  localparam logic [7:0]  TPS_RESET     = 8'd8;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_WAKE   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_FULL   = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] event_id;
  } entry_t;

  // Current wall clock reading.
  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] secs;
  } clk_time_t;

endpackage

@@ hdl/timer_queue_countdown_clock_core.sv @@
// Top level of the timer queue with countdown table and wall clock.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, cmd, seconds, event_id   | in
//  output  | out_valid, out_ready, kind, wake_event,      | out
//          | hours, minutes, secs, last                   |
//  config  | cfg_we, cfg_wdata (ticks_per_second)         | in
//
// An enqueue or a tick that does not complete a second is taken in ST_IDLE;
// ST_EMIT then loads the result register. A tick that completes a second
// first sweeps the filled table entries in ST_SWEEP, one entry per cycle
// unless the output stalls, through the memory's read-modify-write sweep.
// Reset clears the prescaler, fill count, clock and output valid; the table
// needs no clearing. A stalled output holds the sweep on an expired entry.
module timer_queue_countdown_clock_core import tq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] seconds,
  input  logic [15:0] event_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] wake_event,
  output logic [6:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  secs,
  output logic        last
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          we;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          step;
  clk_time_t     now;

  // Control and sweep.
  tq_seq #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .seconds    (seconds),
    .event_id   (event_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .wake_event (wake_event),
    .hours      (hours),
    .minutes    (minutes),
    .secs       (secs),
    .last       (last),
    .we         (we),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .step       (step),
    .now        (now)
  );

  // Timer table.
  tq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Wall clock.
  tq_clock u_clock (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .now  (now)
  );

endmodule

@@ hdl/tq_ram.sv @@
// Timer table memory: one write port, one read port, registered read data.
module tq_ram import tq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/tq_clock.sv @@
// Hours, minutes and seconds counter that advances one second per step.
module tq_clock import tq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  output clk_time_t now
);

  clk_time_t now_next;

  // Carry chain from seconds into minutes into hours.
  always_comb begin
    now_next = now;
    if (step) begin
      if (now.secs == 6'(SECS_PER_MIN - 1)) begin
        now_next.secs = '0;
        if (now.minutes == 6'(MINS_PER_HOUR - 1)) begin
          now_next.minutes = '0;
          if (now.hours == 7'(HOURS_WRAP - 1)) begin
            now_next.hours = '0;
          end else begin
            now_next.hours = now.hours + 7'd1;
          end
        end else begin
          now_next.minutes = now.minutes + 6'd1;
        end
      end else begin
        now_next.secs = now.secs + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else begin
      now <= now_next;
    end
  end

endmodule

@@ hdl/tq_seq.sv @@
// Sequencer: prescaler, table fill count, countdown sweep and result register.
module tq_seq import tq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  // Configuration.
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  // Input channel.
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  input  logic [15:0]   seconds,
  input  logic [15:0]   event_id,
  // Output channel.
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    kind,
  output logic [15:0]   wake_event,
  output logic [6:0]    hours,
  output logic [5:0]    minutes,
  output logic [5:0]    secs,
  output logic          last,
  // Memory port.
  output logic          we,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  // Wall clock.
  output logic          step,
  input  clk_time_t     now
);

  state_t       state, state_next;
  logic [7:0]   tps;
  logic [7:0]   pre, pre_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] wr_ptr, wr_ptr_next;
  kind_t        final_kind, final_kind_next;

  logic [7:0]    pre_inc;
  logic [CW-1:0] idx_inc;
  logic          slot_free;
  logic          expired;
  logic          load_out;
  kind_t         load_kind;
  logic [15:0]   load_event;
  logic          load_last;

  assign pre_inc   = pre + 8'd1;
  assign idx_inc   = idx + CW'(1);
  assign slot_free = !out_valid || out_ready;
  assign expired   = rd_data.remaining <= 16'd1;
  assign in_ready  = (state == ST_IDLE);

  // Next state, memory accesses and result loading.
  always_comb begin
    state_next      = state;
    pre_next        = pre;
    count_next      = count;
    idx_next        = idx;
    wr_ptr_next     = wr_ptr;
    final_kind_next = final_kind;
    we              = 1'b0;
    wr_addr         = wr_ptr[AW-1:0];
    wr_data         = '{remaining: rd_data.remaining - 16'd1, event_id: rd_data.event_id};
    rd_en           = 1'b0;
    rd_addr         = idx_inc[AW-1:0];
    step            = 1'b0;
    load_out        = 1'b0;
    load_kind       = final_kind;
    load_event      = '0;
    load_last       = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_ENQUEUE) begin
            state_next = ST_EMIT;
            if (count < CW'(DEPTH)) begin
              we              = 1'b1;
              wr_addr         = count[AW-1:0];
              wr_data         = '{remaining: seconds, event_id: event_id};
              count_next      = count + CW'(1);
              final_kind_next = KIND_ACCEPT;
            end else begin
              final_kind_next = KIND_FULL;
            end
          end else begin
            final_kind_next = KIND_TICK;
            if (pre_inc == tps) begin
              // One second elapsed: advance the clock, then sweep the table if it holds entries.
              pre_next = '0;
              step     = 1'b1;
              if (count == '0) begin
                state_next = ST_EMIT;
              end else begin
                idx_next    = '0;
                wr_ptr_next = '0;
                rd_en       = 1'b1;
                rd_addr     = '0;
                state_next  = ST_SWEEP;
              end
            end else begin
              pre_next   = pre_inc;
              state_next = ST_EMIT;
            end
          end
        end
      end

      ST_SWEEP: begin
        // Expired entries leave as wake beats; survivors close up at wr_ptr.
        if (!expired || slot_free) begin
          if (expired) begin
            load_out   = 1'b1;
            load_kind  = KIND_WAKE;
            load_event = rd_data.event_id;
            load_last  = 1'b0;
          end else begin
            we          = 1'b1;
            wr_ptr_next = wr_ptr + CW'(1);
          end
          if (idx_inc == count) begin
            count_next = expired ? wr_ptr : wr_ptr + CW'(1);
            state_next = ST_EMIT;
          end else begin
            idx_next = idx_inc;
            rd_en    = 1'b1;
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tps       <= TPS_RESET;
      pre       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pre   <= pre_next;
      count <= count_next;
      if (cfg_we) begin
        tps <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sweep pointers and result payload.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    wr_ptr     <= wr_ptr_next;
    final_kind <= final_kind_next;
    if (load_out) begin
      kind       <= load_kind;
      wake_event <= load_event;
      hours      <= now.hours;
      minutes    <= now.minutes;
      secs       <= now.secs;
      last       <= load_last;
    end
  end

endmodule
